@@ hdl/sorted_index_set_with_position_map_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sorted index set
// Shared property shapes for the checker, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_INDEX_SET_WITH_POSITION_MAP_MACROS_SVH
`define SORTED_INDEX_SET_WITH_POSITION_MAP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/sis_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted index set package
// Widths, operation and status codes, and the shift control shared by the cells.
// ----------------------------------------------------------------------------
package sis_pkg;

	// Field widths of the beats.
	localparam int KIND_W   = 3;
	localparam int IDX_W    = 8;
	localparam int SLOT_W   = 8;
	localparam int STATUS_W = 2;
	localparam int RES_W    = 9;
	localparam int ROW_W    = 9;

	// Default number of cells and the row count after reset.
	localparam int MAX_ROWS_DEF = 256;
	localparam logic [ROW_W-1:0] ROW_RESET = 9'd256;

	// Number of cells folded together in the first level of the match tree.
	localparam int GROUP = 16;

	// Result code for an absent index or an empty slot.
	localparam logic [RES_W-1:0] NONE = 9'h1FF;

	// Operation codes carried in tuser.
	typedef enum logic [KIND_W-1:0] {
		KIND_ADD        = 3'd0,
		KIND_REMOVE     = 3'd1,
		KIND_INVALIDATE = 3'd2,
		KIND_CLEAR      = 3'd3,
		KIND_READ       = 3'd4
	} sis_kind_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_APPLIED  = 2'd0,
		ST_NOCHANGE = 2'd1,
		ST_REJECTED = 2'd2,
		ST_EMPTY    = 2'd3
	} sis_status_t;

	// Shift command broadcast to every cell.
	typedef struct packed {
		logic             insert;
		logic             remove;
		logic [IDX_W-1:0] idx;
	} sis_shift_t;

endpackage

@@ hdl/sis_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted index set cell
// Holds one list slot, compares it against the request and shifts with its
// neighbors on an insert or a remove.
// ----------------------------------------------------------------------------
module sis_cell #(
	parameter int POS   = 0,
	parameter int CNT_W = 9
) (
	input  logic                              clk,
	input  sis_pkg::sis_shift_t               ctrl,
	input  logic [CNT_W-1:0]                  count,
	input  logic [sis_pkg::SLOT_W-1:0]        slot,
	input  logic                              left_lt,
	input  logic [sis_pkg::IDX_W-1:0]         left_entry,
	input  logic                              right_lt,
	input  logic [sis_pkg::IDX_W-1:0]         right_entry,
	output logic [sis_pkg::IDX_W-1:0]         entry,
	output logic                              lt,
	output logic [CNT_W+sis_pkg::IDX_W:0]     word
);
	import sis_pkg::*;

	logic [IDX_W-1:0] entry_q;
	logic             valid;
	logic             lt_c;
	logic             eq_c;
	logic             sel_c;
	logic             lt_s1;
	logic             eq_s1;
	logic             sel_s1;
	logic [CNT_W-1:0] pos_bits;
	logic [IDX_W-1:0] rd_bits;

	// The slot holds a member while it lies below the count.
	assign valid = CNT_W'(POS) < count;
	assign lt_c  = valid && (entry_q < ctrl.idx);
	assign eq_c  = valid && (entry_q == ctrl.idx);
	assign sel_c = valid && (CNT_W'(POS) == CNT_W'(slot));

	// Compare results, registered for the match tree and the shift.
	always_ff @(posedge clk) begin
		lt_s1  <= lt_c;
		eq_s1  <= eq_c;
		sel_s1 <= sel_c;
	end

	// Insert: slots at or past the boundary move up, the boundary takes the index.
	// Remove: slots at or past the removed member take their right neighbor.
	always_ff @(posedge clk) begin
		if (ctrl.insert && !lt_s1) begin
			entry_q <= left_lt ? ctrl.idx : left_entry;
		end else if (ctrl.remove && !lt_s1) begin
			entry_q <= right_entry;
		end
	end

	// The last smaller member reports the insertion point; a selected slot its entry.
	assign pos_bits = (lt_s1 && !right_lt) ? CNT_W'(POS + 1) : '0;
	assign rd_bits  = sel_s1 ? entry_q : '0;
	assign word     = {eq_s1, pos_bits, rd_bits};
	assign entry    = entry_q;
	assign lt       = lt_s1;

endmodule

@@ hdl/sis_or_reduce.sv @@
// ----------------------------------------------------------------------------
// Sorted index set match tree
// Ors the cell words in registered groups, then across the groups.
// ----------------------------------------------------------------------------
module sis_or_reduce #(
	parameter int N     = 256,
	parameter int W     = 18,
	parameter int GSIZE = 16
) (
	input  logic                clk,
	input  logic [N-1:0][W-1:0] din,
	output logic [W-1:0]        dout
);
	localparam int NG = (N + GSIZE - 1) / GSIZE;

	logic [NG-1:0][W-1:0] group_s1;

	// First level: one registered or per group of cells.
	for (genvar g = 0; g < NG; g++) begin : g_grp
		logic [W-1:0] acc;
		always_comb begin
			acc = '0;
			for (int k = 0; k < GSIZE; k++) begin
				if (g * GSIZE + k < N) begin
					acc = acc | din[g * GSIZE + k];
				end
			end
		end
		always_ff @(posedge clk) begin
			group_s1[g] <= acc;
		end
	end

	// Second level: or across the groups.
	always_comb begin
		dout = '0;
		for (int g = 0; g < NG; g++) begin
			dout = dout | group_s1[g];
		end
	end

endmodule

@@ hdl/sorted_index_set_with_position_map.sv @@
// ----------------------------------------------------------------------------
// Sorted index set with position map
// Ascending list of member indices kept in a row of cells, with lookup of the
// slot of any index and read of any slot.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel: tuser holds the operation, tdata the
// index and the slot. Each request gives exactly one result beat on the m_
// channel with status, position, slot entry, member count and rebuild flag.
// A request is taken in the idle state, the cells compare it in the compare
// state, the match tree folds the compare results in the reduce state, and in
// the apply state the cells shift and the result is loaded into the output
// register. The compare register in the cells and the registered first level
// of the match tree set these steps, and the next request is taken the
// cycle after the result is loaded.
// The output register decouples the sides: a new request is taken while a
// result still waits. A stalled receiver holds the block in its last step
// until the output register frees up.
// After reset the list is empty, the rebuild flag is set and row_count is
// 256; a clear is needed before the first add. No clearing pass is needed.
// cfg_we writes row_count and sets the rebuild flag.
// ----------------------------------------------------------------------------
module sorted_index_set_with_position_map #(
	parameter int MAX_ROWS = sis_pkg::MAX_ROWS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [sis_pkg::ROW_W-1:0]  cfg_wdata,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// [7:0] member_index, [15:8] slot
	input  logic [15:0]                s_tdata,
	// [2:0] kind
	input  logic [sis_pkg::KIND_W-1:0] s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [1:0] status, [10:2] position, [19:11] slot_entry, [28:20] member_count,
	// [29] rebuild_needed, [31:30] zero
	output logic [31:0]                m_tdata
);
	import sis_pkg::*;

	localparam int CNT_W = $clog2(MAX_ROWS + 1);
	localparam int WW    = CNT_W + IDX_W + 1;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CMP   = 4'b0010,
		S_RED   = 4'b0100,
		S_APPLY = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [KIND_W-1:0]      kind_q;
	logic [IDX_W-1:0]       idx_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [CNT_W-1:0]       count_q;
	logic                   flag_q;
	logic [ROW_W-1:0]       row_count_q;
	logic                   m_tvalid_q;
	logic [31:0]            m_tdata_q;

	sis_shift_t             shift;
	logic [MAX_ROWS-1:0]    cell_lt;
	logic [MAX_ROWS-1:0][IDX_W-1:0] cell_entry;
	logic [MAX_ROWS-1:0][WW-1:0]    cell_word;
	logic [WW-1:0]          match;

	logic                   present;
	logic [CNT_W-1:0]       at;
	logic [IDX_W-1:0]       rd_entry;
	logic                   fire;
	logic                   rej;
	logic                   out_free;

	logic [STATUS_W-1:0]    status_d;
	logic [RES_W-1:0]       pos_d;
	logic [RES_W-1:0]       entry_d;
	logic [CNT_W-1:0]       count_d;
	logic                   flag_d;
	logic                   ins_d;
	logic                   rem_d;

	// Row of cells, each linked to its neighbors.
	for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
		logic             l_lt;
		logic [IDX_W-1:0] l_entry;
		logic             r_lt;
		logic [IDX_W-1:0] r_entry;
		if (i == 0) begin : g_first
			assign l_lt    = 1'b1;
			assign l_entry = idx_q;
		end else begin : g_inner_l
			assign l_lt    = cell_lt[i-1];
			assign l_entry = cell_entry[i-1];
		end
		if (i == MAX_ROWS - 1) begin : g_last
			assign r_lt    = 1'b0;
			assign r_entry = '0;
		end else begin : g_inner_r
			assign r_lt    = cell_lt[i+1];
			assign r_entry = cell_entry[i+1];
		end
		sis_cell #(
			.POS   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk         (clk),
			.ctrl        (shift),
			.count       (count_q),
			.slot        (slot_q),
			.left_lt     (l_lt),
			.left_entry  (l_entry),
			.right_lt    (r_lt),
			.right_entry (r_entry),
			.entry       (cell_entry[i]),
			.lt          (cell_lt[i]),
			.word        (cell_word[i])
		);
	end

	// Fold the cell words into presence, insertion point and read entry.
	sis_or_reduce #(
		.N     (MAX_ROWS),
		.W     (WW),
		.GSIZE (GROUP)
	) u_reduce (
		.clk  (clk),
		.din  (cell_word),
		.dout (match)
	);

	assign present  = match[WW-1];
	assign at       = match[IDX_W +: CNT_W];
	assign rd_entry = match[IDX_W-1:0];

	assign out_free = !m_tvalid_q || m_tready;
	assign fire     = (state_q == S_APPLY) && out_free;
	assign s_tready = (state_q == S_IDLE);
	assign rej      = flag_q || (ROW_W'(idx_q) >= row_count_q) || (int'(idx_q) >= MAX_ROWS);

	// Result and next state of the list for the request in hand.
	always_comb begin
		status_d = ST_NOCHANGE;
		pos_d    = present ? RES_W'(at) : NONE;
		entry_d  = NONE;
		count_d  = count_q;
		flag_d   = flag_q;
		ins_d    = 1'b0;
		rem_d    = 1'b0;
		unique case (kind_q)
			KIND_ADD: begin
				if (rej) begin
					status_d = ST_REJECTED;
					flag_d   = 1'b1;
				end else if (present) begin
					status_d = ST_NOCHANGE;
				end else begin
					status_d = ST_APPLIED;
					ins_d    = 1'b1;
					count_d  = count_q + CNT_W'(1);
					pos_d    = RES_W'(at);
				end
			end
			KIND_REMOVE: begin
				if (rej) begin
					status_d = ST_REJECTED;
					flag_d   = 1'b1;
				end else if (!present) begin
					status_d = ST_NOCHANGE;
				end else begin
					status_d = ST_APPLIED;
					rem_d    = 1'b1;
					count_d  = count_q - CNT_W'(1);
					pos_d    = NONE;
				end
			end
			KIND_INVALIDATE: begin
				status_d = ST_APPLIED;
				flag_d   = 1'b1;
			end
			KIND_CLEAR: begin
				status_d = ST_APPLIED;
				count_d  = '0;
				flag_d   = 1'b0;
				pos_d    = NONE;
			end
			KIND_READ: begin
				if (CNT_W'(slot_q) < count_q && (SLOT_W < CNT_W || slot_q < SLOT_W'(count_q))) begin
					status_d = ST_APPLIED;
					entry_d  = RES_W'(rd_entry);
				end else begin
					status_d = ST_EMPTY;
				end
			end
			default: begin
				status_d = ST_NOCHANGE;
			end
		endcase
	end

	// Shift command to the cells, live only in the cycle the result is loaded.
	assign shift.insert = fire && ins_d;
	assign shift.remove = fire && rem_d;
	assign shift.idx    = idx_q;

	// Request capture.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q <= s_tuser;
			idx_q  <= s_tdata[7:0];
			slot_q <= s_tdata[15:8];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (s_tvalid) state_q <= S_CMP;
				S_CMP:   state_q <= S_RED;
				S_RED:   state_q <= S_APPLY;
				S_APPLY: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// List count, rebuild flag and row count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			flag_q      <= 1'b1;
			row_count_q <= ROW_RESET;
		end else begin
			if (fire) begin
				count_q <= count_d;
				flag_q  <= flag_d;
			end
			if (cfg_we) begin
				row_count_q <= cfg_wdata;
				flag_q      <= 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tdata_q <= {2'b00, flag_d, RES_W'(count_d), entry_d, pos_d, status_d};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ hdl/sis_checker.sv @@
// ----------------------------------------------------------------------------
// Sorted index set port checker
// Watches the top level's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "sorted_index_set_with_position_map_macros.svh"

module sis_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);
	import sis_pkg::*;

	// A result beat stays offered while the receiver stalls.
	`SIS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")

	// Requests are worked one at a time: no beat is taken right after another.
	`SIS_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request taken while busy")

	// A rejected request always leaves the rebuild flag set.
	`SIS_ASSERT_NOW(a_reject_flag, m_tvalid && (m_tdata[1:0] == ST_REJECTED), m_tdata[29], "reject without rebuild flag")

	// An empty slot read returns no entry.
	`SIS_ASSERT_NOW(a_empty_none, m_tvalid && (m_tdata[1:0] == ST_EMPTY), m_tdata[19:11] == NONE, "empty slot with an entry")

endmodule

bind sorted_index_set_with_position_map sis_checker u_sis_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the sorted index set with position map
// Requests are queued by a stimulus process and presented by a clocked driver;
// a clocked monitor runs a behavioral model of the list on every accepted
// request beat and compares each result beat field by field. The run walks
// through several row_count settings, fills the list to its full size, and
// stalls the result side long enough to back up the request side.
// ----------------------------------------------------------------------------
module testbench;
	import sis_pkg::*;

	// First operation code that the block does not use.
	localparam logic [KIND_W-1:0] KIND_FIRST_UNUSED = 3'd5;
	// Length of the long result-side stall, in cycles.
	localparam int LONG_HOLD = 400;
	// Cycles to watch for stray beats once every result has come.
	localparam int TAIL_CYCLES = 16;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  member_index;
		logic [SLOT_W-1:0] slot;
	} op_req_t;

	typedef struct {
		sis_status_t      status;
		logic [RES_W-1:0] position;
		logic [RES_W-1:0] slot_entry;
		logic [ROW_W-1:0] member_count;
		logic             rebuild;
	} op_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [ROW_W-1:0]  cfg_wdata = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata = '0;
	logic [KIND_W-1:0] s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [31:0]       m_tdata;

	// Stimulus queue and bookkeeping between the processes.
	op_req_t    pending_ops[$];
	op_result_t expected_results[$];
	op_req_t    next_op;
	int         ops_owed = 0;
	bit         req_beat_taken = 1'b0;
	int         src_idle_pct = 16;
	int         sink_idle_pct = 16;
	bit         sink_hold_req = 1'b0;
	int         sink_hold_left = 0;
	int         rows_gen = ROW_RESET;
	int         mismatches = 0;
	int         results_seen = 0;

	// Model of the list, its reverse map and the register.
	logic [IDX_W-1:0] mdl_entries[MAX_ROWS_DEF];
	logic [RES_W-1:0] mdl_slot_of[MAX_ROWS_DEF];
	logic [ROW_W-1:0] mdl_count;
	logic             mdl_invalid;
	logic [ROW_W-1:0] mdl_rows;

	sorted_index_set_with_position_map dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#400000;
		$display("testbench NOT OK");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH beat %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [RES_W-1:0] got,
			input logic [RES_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// Empty list with every index absent.
	task automatic model_clear();
		foreach (mdl_slot_of[i])
			mdl_slot_of[i] = NONE;
		mdl_count = '0;
	endtask

	// Apply one request to the list model and work out its result.
	task automatic apply_to_model(input op_req_t rq, output op_result_t res);
		int lim;
		int at;
		int p;
		int idx;
		logic [IDX_W-1:0] moved;
		idx = rq.member_index;
		lim = (mdl_rows < MAX_ROWS_DEF) ? int'(mdl_rows) : MAX_ROWS_DEF;
		res.status = ST_NOCHANGE;
		res.slot_entry = NONE;
		case (rq.kind)
			KIND_ADD, KIND_REMOVE: begin
				if (idx >= lim || mdl_invalid) begin
					mdl_invalid = 1'b1;
					res.status = ST_REJECTED;
				end else if (rq.kind == KIND_ADD) begin
					if (mdl_slot_of[idx] == NONE) begin
						// Find the sorted place and move the later entries up.
						at = 0;
						while (at < mdl_count && mdl_entries[at] < idx)
							at++;
						for (p = mdl_count; p > at; p--) begin
							moved = mdl_entries[p-1];
							mdl_entries[p] = moved;
							mdl_slot_of[moved] = RES_W'(p);
						end
						mdl_entries[at] = rq.member_index;
						mdl_slot_of[idx] = RES_W'(at);
						mdl_count++;
						res.status = ST_APPLIED;
					end
				end else if (mdl_slot_of[idx] != NONE) begin
					// Move the later entries down over the removed one.
					for (p = mdl_slot_of[idx]; p + 1 < mdl_count; p++) begin
						moved = mdl_entries[p+1];
						mdl_entries[p] = moved;
						mdl_slot_of[moved] = RES_W'(p);
					end
					mdl_slot_of[idx] = NONE;
					mdl_count--;
					res.status = ST_APPLIED;
				end
			end
			KIND_INVALIDATE: begin
				mdl_invalid = 1'b1;
				res.status = ST_APPLIED;
			end
			KIND_CLEAR: begin
				model_clear();
				mdl_invalid = 1'b0;
				res.status = ST_APPLIED;
			end
			KIND_READ: begin
				if (rq.slot < mdl_count) begin
					res.slot_entry = {1'b0, mdl_entries[rq.slot]};
					res.status = ST_APPLIED;
				end else begin
					res.status = ST_EMPTY;
				end
			end
			default: res.status = ST_NOCHANGE;
		endcase
		res.position = mdl_slot_of[idx];
		res.member_count = mdl_count;
		res.rebuild = mdl_invalid;
	endtask

	// Monitor: checks result beats, then feeds accepted request beats and
	// register writes to the model.
	always @(posedge clk) begin
		op_req_t    rq;
		op_result_t res;
		op_result_t want;
		if (arst_n) begin
			if (m_tvalid === 1'b1 && m_tready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result beat %h", m_tdata));
				end else begin
					want = expected_results.pop_front();
					check_field("status", {7'd0, m_tdata[1:0]}, {7'd0, want.status});
					check_field("position", m_tdata[10:2], want.position);
					check_field("slot_entry", m_tdata[19:11], want.slot_entry);
					check_field("member_count", m_tdata[28:20], want.member_count);
					check_field("rebuild_needed", {8'd0, m_tdata[29]}, {8'd0, want.rebuild});
					check_field("padding", {7'd0, m_tdata[31:30]}, '0);
				end
			end
			if (cfg_we) begin
				mdl_rows = cfg_wdata;
				mdl_invalid = 1'b1;
			end
			req_beat_taken = s_tvalid && s_tready;
			if (req_beat_taken) begin
				rq.member_index = s_tdata[7:0];
				rq.slot = s_tdata[15:8];
				rq.kind = s_tuser;
				apply_to_model(rq, res);
				expected_results.insert(expected_results.size(), res);
				ops_owed--;
			end
		end
	end

	// Driver: presents queued requests, with random gaps between beats.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || req_beat_taken) begin
			if (pending_ops.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				next_op = pending_ops.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {next_op.slot, next_op.member_index};
				s_tuser <= next_op.kind;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (sink_hold_req) begin
			sink_hold_left = LONG_HOLD;
			sink_hold_req = 1'b0;
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_hold_left > 0) begin
			m_tready <= 1'b0;
			sink_hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic push_op(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
			input logic [SLOT_W-1:0] slot);
		op_req_t rq;
		rq.kind = kind;
		rq.member_index = idx;
		rq.slot = slot;
		pending_ops.insert(pending_ops.size(), rq);
		ops_owed++;
	endtask

	// Wait until every queued request has been taken and answered.
	task automatic wait_drained();
		while (ops_owed != 0 || expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_rows(input int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= ROW_W'(value);
		rows_gen = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int row_limit_gen();
		return (rows_gen < MAX_ROWS_DEF) ? rows_gen : MAX_ROWS_DEF;
	endfunction

	// Mostly a narrow band so that adds and removes hit present indices.
	function automatic logic [IDX_W-1:0] pick_index();
		int lim;
		lim = row_limit_gen();
		if ($urandom_range(1))
			return IDX_W'($urandom_range((lim < 32 ? lim : 32) - 1, 0));
		return IDX_W'($urandom_range(lim - 1, 0));
	endfunction

	function automatic logic [SLOT_W-1:0] pick_slot();
		if ($urandom_range(9) == 0)
			return SLOT_W'($urandom_range(255, 0));
		return SLOT_W'($urandom_range(40, 0));
	endfunction

	task automatic push_valid_op();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			push_op(KIND_ADD, pick_index(), pick_slot());
		else if (r < 72)
			push_op(KIND_REMOVE, pick_index(), pick_slot());
		else
			push_op(KIND_READ, pick_index(), pick_slot());
	endtask

	// A clear, then well-formed traffic with some noise and broken sequences.
	task automatic push_mixed(input int n);
		int r;
		int k;
		push_op(KIND_CLEAR, pick_index(), pick_slot());
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 88) begin
				push_valid_op();
			end else if (r < 92) begin
				push_op(KIND_FIRST_UNUSED + KIND_W'($urandom_range(2, 0)),
					pick_index(), pick_slot());
			end else begin
				// Break the list, try a few requests, then recover with a clear.
				if (row_limit_gen() < MAX_ROWS_DEF && $urandom_range(1))
					push_op($urandom_range(1) ? KIND_ADD : KIND_REMOVE,
						IDX_W'($urandom_range(255, row_limit_gen())), pick_slot());
				else
					push_op(KIND_INVALIDATE, pick_index(), pick_slot());
				k = $urandom_range(2, 0);
				for (int j = 0; j < k; j++)
					push_valid_op();
				push_op(KIND_CLEAR, pick_index(), pick_slot());
			end
		end
	endtask

	// Stimulus sequence.
	initial begin
		int perm[MAX_ROWS_DEF];
		int j;
		int tmp;
		mdl_rows = ROW_RESET;
		mdl_invalid = 1'b1;
		model_clear();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Out of reset the list is invalid: add and remove are refused.
		push_op(KIND_ADD, 5, 0);
		push_op(KIND_REMOVE, 5, 0);
		push_op(KIND_READ, 5, 0);
		push_op(KIND_CLEAR, 0, 0);
		push_op(KIND_ADD, 255, 0);
		push_op(KIND_ADD, 0, 0);
		push_op(KIND_ADD, 128, 0);
		push_op(KIND_ADD, 128, 0);
		push_op(KIND_ADD, 64, 0);
		push_op(KIND_READ, 0, 0);
		push_op(KIND_READ, 64, 3);
		push_op(KIND_READ, 0, 4);
		push_op(KIND_READ, 0, 255);
		push_op(KIND_REMOVE, 77, 0);
		push_op(KIND_REMOVE, 0, 0);
		push_op(KIND_REMOVE, 255, 1);
		push_op(KIND_FIRST_UNUSED, 64, 0);
		push_op(KIND_FIRST_UNUSED + 3'd1, 128, 1);
		push_op(KIND_FIRST_UNUSED + 3'd2, 170, 85);
		push_op(KIND_INVALIDATE, 64, 0);
		push_op(KIND_ADD, 10, 0);
		push_op(KIND_READ, 128, 1);
		push_op(KIND_CLEAR, 64, 0);
		wait_drained();

		// No valid rows: every index is out of range.
		write_rows(0);
		push_op(KIND_CLEAR, 0, 0);
		push_op(KIND_ADD, 0, 0);
		push_op(KIND_CLEAR, 0, 0);
		push_op(KIND_REMOVE, 200, 0);
		push_op(KIND_READ, 0, 0);
		wait_drained();

		// One valid row.
		write_rows(1);
		push_op(KIND_CLEAR, 0, 0);
		push_op(KIND_ADD, 0, 0);
		push_op(KIND_ADD, 1, 0);
		push_op(KIND_REMOVE, 0, 0);
		push_op(KIND_CLEAR, 0, 0);
		push_op(KIND_ADD, 0, 0);
		wait_drained();

		// Fill every row in random order and empty it again, without idling
		// and with one long result-side stall at the start.
		write_rows(256);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		foreach (perm[i])
			perm[i] = i;
		for (int i = MAX_ROWS_DEF - 1; i > 0; i--) begin
			j = $urandom_range(i, 0);
			tmp = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
		push_op(KIND_CLEAR, 0, 0);
		sink_hold_req = 1'b1;
		foreach (perm[i])
			push_op(KIND_ADD, IDX_W'(perm[i]), pick_slot());
		push_op(KIND_READ, 255, 255);
		push_op(KIND_READ, 0, 0);
		push_op(KIND_ADD, IDX_W'(perm[0]), 0);
		for (int i = MAX_ROWS_DEF - 1; i > 0; i--) begin
			j = $urandom_range(i, 0);
			tmp = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
		foreach (perm[i]) begin
			push_op(KIND_REMOVE, IDX_W'(perm[i]), pick_slot());
			if ($urandom_range(15) == 0)
				push_op(KIND_READ, pick_index(), SLOT_W'($urandom_range(255, 0)));
		end
		wait_drained();
		src_idle_pct = 16;
		sink_idle_pct = 16;

		// Random traffic under several row counts.
		write_rows(255);
		push_mixed(30);
		wait_drained();
		write_rows(100);
		push_mixed(30);
		wait_drained();
		write_rows(2);
		push_mixed(20);
		wait_drained();
		write_rows($urandom_range(256, 2));
		push_mixed(30);
		wait_drained();
		write_rows(256);
		push_mixed(40);
		wait_drained();

		// Watch for stray result beats before deciding.
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
